>>> rtl/dcc_pkg.sv
// Shared constants, widths and types for the day-count to civil-date converter.
// No dependencies; every module of the block imports this package.
`default_nettype none

package dcc_pkg;

    // Field widths and stream packing
    localparam int COUNT_BITS    = 22;
    localparam int IN_DATA_BITS  = ((COUNT_BITS + 7) / 8) * 8;
    localparam int EPOCH_BITS    = 14;
    localparam int YEAR_BITS     = 15;
    localparam int MONTH_BITS    = 4;
    localparam int DAY_BITS      = 5;
    localparam int OUT_DATA_BITS = ((YEAR_BITS + MONTH_BITS + DAY_BITS + 7) / 8) * 8;

    // Register file
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-3:0] REG_EPOCH_YEAR = '0;

    // Calendar constants
    localparam int COMMON_YEAR_DAYS = 365;
    localparam int DAYS_PER_4    = 1461;
    localparam int DAYS_PER_100  = 36524;
    localparam int DAYS_PER_400  = 146097;
    localparam int EPOCH_RESET   = 1970;
    localparam int EPOCH_DAYS_RESET = COMMON_YEAR_DAYS * EPOCH_RESET + (EPOCH_RESET + 3) / 4
                                    - (EPOCH_RESET + 99) / 100 + (EPOCH_RESET + 399) / 400;

    // Internal widths
    localparam int EDAYS_BITS     = 23;
    localparam int ABS_BITS       = ((COUNT_BITS > EDAYS_BITS) ? COUNT_BITS : EDAYS_BITS) + 1;
    localparam int Q400_BITS      = ABS_BITS - 17;
    localparam int REM400_BITS    = 18;
    localparam int REM100_BITS    = 16;
    localparam int Q4_BITS        = 5;
    localparam int REM4_BITS      = 11;
    localparam int DOY_BITS       = 9;
    localparam int FULL_YEAR_BITS = Q400_BITS + 10;
    localparam int C100_BITS      = EPOCH_BITS - 5;

    // Reciprocals for exact floor division by constants
    localparam int RECIP400_SHIFT = ABS_BITS + 18;
    localparam int RECIP400_BITS  = ABS_BITS + 1;
    localparam longint RECIP400_L = ((longint'(1) << RECIP400_SHIFT) + DAYS_PER_400 - 1)
                                    / DAYS_PER_400;
    localparam logic [RECIP400_BITS-1:0] RECIP400 = RECIP400_BITS'(RECIP400_L);

    localparam int RECIP4_SHIFT = REM100_BITS + 11;
    localparam int RECIP4_BITS  = RECIP4_SHIFT - 10;
    localparam longint RECIP4_L = ((longint'(1) << RECIP4_SHIFT) + DAYS_PER_4 - 1) / DAYS_PER_4;
    localparam logic [RECIP4_BITS-1:0] RECIP4 = RECIP4_BITS'(RECIP4_L);

    localparam int RECIP100_SHIFT = EPOCH_BITS + 1 + 7;
    localparam int RECIP100_BITS  = RECIP100_SHIFT - 6;
    localparam longint RECIP100_L = ((longint'(1) << RECIP100_SHIFT) + 100 - 1) / 100;
    localparam logic [RECIP100_BITS-1:0] RECIP100 = RECIP100_BITS'(RECIP100_L);

    // First day of each month in a common year, zero based
    localparam logic [DOY_BITS-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Year and day of year handed to the month stage
    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [DOY_BITS-1:0]  doy;
        logic                 leap;
    } t_year_day;

endpackage

`default_nettype wire

>>> rtl/dcc_cfg.sv
// Configuration registers: epoch year and its absolute day number.
// Depends on dcc_pkg.
`default_nettype none

module dcc_cfg import dcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    output logic [EDAYS_BITS-1:0]     o_epoch_days
);

    logic                          reg_sel;
    logic                          wr_en;
    logic [EPOCH_BITS-1:0]         n_epoch;
    logic [EPOCH_BITS:0]           y_plus99;
    logic [EPOCH_BITS+RECIP100_BITS:0] c100_prod;
    logic [C100_BITS-1:0]          c100;
    logic [C100_BITS-1:0]          c400;
    logic [EPOCH_BITS-1:0]         q4;
    logic [EDAYS_BITS-1:0]         n_epoch_days;
    logic [EPOCH_BITS-1:0]         r_epoch;
    logic [EDAYS_BITS-1:0]         r_epoch_days;

    // Decode the word address; byte offset bits are ignored
    assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_EPOCH_YEAR);
    assign wr_en   = psel & penable & pwrite & reg_sel;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DATA_BITS'(r_epoch) : '0;
    assign o_epoch_days = r_epoch_days;

    // Days from 1 January of year 0 to 1 January of the written year
    always_comb begin
        n_epoch   = pwdata[EPOCH_BITS-1:0];
        y_plus99  = {1'b0, n_epoch} + (EPOCH_BITS+1)'(99);
        c100_prod = (EPOCH_BITS+RECIP100_BITS+1)'(y_plus99)
                  * (EPOCH_BITS+RECIP100_BITS+1)'(RECIP100);
        c100      = c100_prod[RECIP100_SHIFT +: C100_BITS];
        c400      = C100_BITS'((c100 + C100_BITS'(3)) >> 2);
        q4        = EPOCH_BITS'(({1'b0, n_epoch} + (EPOCH_BITS+1)'(3)) >> 2);
        n_epoch_days = EDAYS_BITS'(n_epoch) * EDAYS_BITS'(COMMON_YEAR_DAYS)
                     + EDAYS_BITS'(q4) - EDAYS_BITS'(c100) + EDAYS_BITS'(c400);
    end

    // Hold the epoch and its day number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch      <= EPOCH_BITS'(EPOCH_RESET);
            r_epoch_days <= EDAYS_BITS'(EPOCH_DAYS_RESET);
        end else if (wr_en) begin
            r_epoch      <= n_epoch;
            r_epoch_days <= n_epoch_days;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dcc_year.sv
// Year split pipeline: 400-year cycles, centuries, 4-year cycles, single years.
// Depends on dcc_pkg; feeds dcc_month with year, day of year and leap flag.
`default_nettype none

module dcc_year import dcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [ABS_BITS-1:0] i_abs,
    output logic                o_ready,
    output logic                o_valid,
    output t_year_day           o_res,
    input  logic                i_ready
);

    // Stage A: quotient by 400-year cycle
    logic                              r_a_valid;
    logic [ABS_BITS-1:0]               r_a_abs;
    logic [Q400_BITS-1:0]              r_a_q400;
    logic [ABS_BITS+RECIP400_BITS-1:0] prod400;
    logic                              ready_a;

    // Stage B: century split
    logic                        r_b_valid;
    logic [Q400_BITS-1:0]        r_b_q400;
    logic [1:0]                  r_b_cent;
    logic [REM100_BITS-1:0]      r_b_r100;
    logic                        r_b_short;
    logic [Q400_BITS+17:0]       cyc_days;
    logic [REM400_BITS-1:0]      rem400;
    logic [1:0]                  cent;
    logic [REM400_BITS-1:0]      cent_days;
    logic [REM100_BITS-1:0]      r100;
    logic                        ready_b;

    // Stage C: quotient by 4-year cycle
    logic                            r_c_valid;
    logic [Q400_BITS-1:0]            r_c_q400;
    logic [1:0]                      r_c_cent;
    logic [REM100_BITS-1:0]          r_c_r100;
    logic                            r_c_short;
    logic [Q4_BITS-1:0]              r_c_q4;
    logic [REM100_BITS+RECIP4_BITS-1:0] prod4;
    logic                            ready_c;

    // Stage D: single years and day of year
    logic                      r_d_valid;
    t_year_day                 r_d_res;
    logic [REM4_BITS-1:0]      r4;
    logic [REM4_BITS-1:0]      rr;
    logic [1:0]                yr;
    logic [DOY_BITS-1:0]       doy;
    logic [FULL_YEAR_BITS-1:0] year_full;
    logic                      ready_d;

    assign ready_d = !r_d_valid || i_ready;
    assign ready_c = !r_c_valid || ready_d;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_d_valid;
    assign o_res   = r_d_res;

    // Reciprocal multiply for the 400-year quotient
    assign prod400 = (ABS_BITS+RECIP400_BITS)'(i_abs) * (ABS_BITS+RECIP400_BITS)'(RECIP400);

    // Remainder in the cycle, then century by threshold compare
    always_comb begin
        cyc_days = (Q400_BITS+18)'(r_a_q400) * (Q400_BITS+18)'(DAYS_PER_400);
        rem400   = r_a_abs[REM400_BITS-1:0] - cyc_days[REM400_BITS-1:0];
        if (rem400 < REM400_BITS'(DAYS_PER_100 + 1)) begin
            cent = 2'd0;
        end else if (rem400 < REM400_BITS'(2 * DAYS_PER_100 + 1)) begin
            cent = 2'd1;
        end else if (rem400 < REM400_BITS'(3 * DAYS_PER_100 + 1)) begin
            cent = 2'd2;
        end else begin
            cent = 2'd3;
        end
        case (cent)
            2'd0:    cent_days = '0;
            2'd1:    cent_days = REM400_BITS'(DAYS_PER_100);
            2'd2:    cent_days = REM400_BITS'(2 * DAYS_PER_100);
            default: cent_days = REM400_BITS'(3 * DAYS_PER_100);
        endcase
        r100 = REM100_BITS'(rem400 - cent_days);
    end

    // Reciprocal multiply for the 4-year quotient
    assign prod4 = (REM100_BITS+RECIP4_BITS)'(r_b_r100) * (REM100_BITS+RECIP4_BITS)'(RECIP4);

    // Single years; a century that opens with a common year has no leap in its first group
    always_comb begin
        r4 = REM4_BITS'(r_c_r100 - REM100_BITS'(r_c_q4) * REM100_BITS'(DAYS_PER_4));
        rr = r_c_short ? (r4 - REM4_BITS'(1)) : r4;
        if (r_c_short) begin
            if (rr < REM4_BITS'(COMMON_YEAR_DAYS)) begin
                yr = 2'd0;
            end else if (rr < REM4_BITS'(2 * COMMON_YEAR_DAYS)) begin
                yr = 2'd1;
            end else if (rr < REM4_BITS'(3 * COMMON_YEAR_DAYS)) begin
                yr = 2'd2;
            end else begin
                yr = 2'd3;
            end
            doy = DOY_BITS'(rr - REM4_BITS'(yr) * REM4_BITS'(COMMON_YEAR_DAYS));
        end else begin
            if (rr < REM4_BITS'(COMMON_YEAR_DAYS + 1)) begin
                yr = 2'd0;
            end else if (rr < REM4_BITS'(2 * COMMON_YEAR_DAYS + 1)) begin
                yr = 2'd1;
            end else if (rr < REM4_BITS'(3 * COMMON_YEAR_DAYS + 1)) begin
                yr = 2'd2;
            end else begin
                yr = 2'd3;
            end
            if (yr == 2'd0) begin
                doy = DOY_BITS'(rr);
            end else begin
                doy = DOY_BITS'(rr - REM4_BITS'(1)
                                - REM4_BITS'(yr) * REM4_BITS'(COMMON_YEAR_DAYS));
            end
        end
        year_full = FULL_YEAR_BITS'(r_c_q400) * FULL_YEAR_BITS'(400)
                  + FULL_YEAR_BITS'(r_c_cent) * FULL_YEAR_BITS'(100)
                  + FULL_YEAR_BITS'({r_c_q4, 2'b00})
                  + FULL_YEAR_BITS'(yr);
    end

    // Advance each stage when the one after it has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
            if (ready_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_abs  <= i_abs;
            r_a_q400 <= prod400[RECIP400_SHIFT +: Q400_BITS];
        end
        if (ready_b) begin
            r_b_q400  <= r_a_q400;
            r_b_cent  <= cent;
            r_b_r100  <= r100;
            r_b_short <= (cent != 2'd0) && (r100 < REM100_BITS'(DAYS_PER_4));
        end
        if (ready_c) begin
            r_c_q400  <= r_b_q400;
            r_c_cent  <= r_b_cent;
            r_c_r100  <= r_b_r100;
            r_c_short <= r_b_short;
            r_c_q4    <= r_b_short ? '0 : prod4[RECIP4_SHIFT +: Q4_BITS];
        end
        if (ready_d) begin
            r_d_res.year <= year_full[YEAR_BITS-1:0];
            r_d_res.doy  <= doy;
            r_d_res.leap <= !r_c_short && (yr == 2'd0);
        end
    end

endmodule

`default_nettype wire

>>> rtl/dcc_month.sv
// Month and day-of-month lookup and the result register of the stream output.
// Depends on dcc_pkg (month start table, t_year_day).
`default_nettype none

module dcc_month import dcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_year_day             i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [YEAR_BITS-1:0]  o_year,
    output logic [MONTH_BITS-1:0] o_month,
    output logic [DAY_BITS-1:0]   o_day,
    input  logic                  i_ready
);

    logic                  r_valid;
    logic [YEAR_BITS-1:0]  r_year;
    logic [MONTH_BITS-1:0] r_month;
    logic [DAY_BITS-1:0]   r_day;
    logic [DOY_BITS-1:0]   start [12];
    logic [DOY_BITS-1:0]   offs  [12];
    logic [MONTH_BITS-1:0] n_month;
    logic [DAY_BITS-1:0]   n_day;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

    // Count month starts passed; February gains a day in leap years
    always_comb begin
        n_month = '0;
        for (int m = 0; m < 12; m++) begin
            start[m] = MONTH_START[m] + DOY_BITS'(i_res.leap && (m >= 2));
            offs[m]  = i_res.doy - start[m];
            if (m != 0 && i_res.doy >= start[m]) begin
                n_month = n_month + MONTH_BITS'(1);
            end
        end
        n_day = '0;
        for (int m = 0; m < 12; m++) begin
            if (n_month == MONTH_BITS'(m)) begin
                n_day = DAY_BITS'(offs[m] + DOY_BITS'(1));
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_year  <= i_res.year;
            r_month <= n_month;
            r_day   <= n_day;
        end
    end

endmodule

`default_nettype wire

>>> rtl/day_count_to_civil_date.sv
// Top level of the day-count to civil-date converter: input register and stream ports.
// Depends on dcc_pkg, dcc_cfg, dcc_year and dcc_month.
`default_nettype none

// Converts a count of days after 1 January of the epoch year into the proleptic
// Gregorian year, zero-based month and one-based day. One result leaves per
// cycle while the output is not stalled; requests pass through the six-register
// pipeline (input register, 400-year quotient, century split, 4-year quotient,
// year and day of year, month lookup). Stalls on the output propagate back
// stage by stage, so empty stages keep filling while a result waits. The epoch
// year is register 0 of the APB port (reset 1970); a write applies to requests
// accepted from the following cycle on.
module day_count_to_civil_date import dcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    // request stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   i_s_axis_tdata,   // [21:0] day_count, rest zero
    // result stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata    // [14:0] year, [18:15] month_index,
                                                        // [23:19] day_of_month
);

    logic [EDAYS_BITS-1:0] epoch_days;
    logic                  r_in_valid;
    logic [ABS_BITS-1:0]   r_abs;
    logic                  year_ready;
    logic                  year_valid;
    t_year_day             year_res;
    logic                  month_ready;
    logic [YEAR_BITS-1:0]  out_year;
    logic [MONTH_BITS-1:0] out_month;
    logic [DAY_BITS-1:0]   out_day;

    dcc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_epoch_days (epoch_days)
    );

    // Take a request when the input register is free or moving on
    assign o_s_axis_tready = !r_in_valid || year_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Absolute day number from year 0
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_abs <= ABS_BITS'(epoch_days) + ABS_BITS'(i_s_axis_tdata[COUNT_BITS-1:0]);
        end
    end

    dcc_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_abs   (r_abs),
        .o_ready (year_ready),
        .o_valid (year_valid),
        .o_res   (year_res),
        .i_ready (month_ready)
    );

    dcc_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (year_valid),
        .i_res   (year_res),
        .o_ready (month_ready),
        .o_valid (o_m_axis_tvalid),
        .o_year  (out_year),
        .o_month (out_month),
        .o_day   (out_day),
        .i_ready (i_m_axis_tready)
    );

    // Pack the result fields, year in the low bits
    assign o_m_axis_tdata = OUT_DATA_BITS'({out_day, out_month, out_year});

endmodule

`default_nettype wire

>>> rtl/dcc_checker.sv
// Port-level checks for the day-count to civil-date converter, bound to its top level.
// Depends on dcc_pkg and day_count_to_civil_date.
`default_nettype none

module dcc_checker import dcc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata
);

    localparam int MONTH_LO = YEAR_BITS;
    localparam int DAY_LO   = YEAR_BITS + MONTH_BITS;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Every result has a month index of at most 11 and a nonzero day
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[DAY_LO-1:MONTH_LO] <= MONTH_BITS'(11))
            && (o_m_axis_tdata[DAY_LO+DAY_BITS-1:DAY_LO] != '0))
        else $error("month or day out of range");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind day_count_to_civil_date dcc_checker u_dcc_checker (.*);

`default_nettype wire
